### rtl/rct_pkg.sv
// Shared constants, types and helpers for the color transform and residual block.
package rct_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_WIDTH_W = 13;
  localparam int CMP_W       = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
  localparam int SYM_W       = 9;
  localparam int DATA_W      = 32;

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_INV = 1'b1;

  // One pixel of the line store: Y in the low bits, then Cb, then Cr.
  typedef struct packed {
    logic [8:0] cr;
    logic [8:0] cb;
    logic [7:0] y;
  } pix_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    pix_t             data;
  } store_wr_t;

  // Lane results carried into the merge stage.
  typedef struct packed {
    logic              mode;
    logic              last;
    logic [SYM_W-1:0]  sym_a;
    logic [SYM_W-1:0]  sym_b;
    logic [SYM_W-1:0]  sym_c;
    logic signed [8:0] rec_y;
    logic signed [8:0] rec_cb;
    logic signed [8:0] rec_cr;
  } lane_res_t;

  // Add or remove the 128 offset of an 8-bit sample: flip the top bit.
  function automatic logic [7:0] bias128(input logic [7:0] v);
    return {~v[7], v[6:0]};
  endfunction

endpackage

### rtl/rct_line_store.sv
// Row-above store with a clearing sweep after reset and a registered read port.
module rct_line_store (
  input  logic                          clk,
  input  logic                          rst,
  input  rct_pkg::store_wr_t            wr,
  input  logic [rct_pkg::COL_W-1:0]     raddr,
  output rct_pkg::pix_t                 rdata,
  output logic                          clearing
);

  rct_pkg::pix_t             mem [rct_pkg::MAX_WIDTH];
  logic [rct_pkg::COL_W-1:0] clr_addr;

  // Sweep every entry to zero once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == rct_pkg::COL_W'(rct_pkg::MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Forward a same-cycle write so a one-pixel row sees its own update.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == raddr)) begin
      rdata <= wr.data;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rct_lane.sv
// One channel lane: clamped median prediction, residual wrap and zigzag, or reconstruction.
module rct_lane (
  input  logic                          mode,
  input  logic                          is_luma,
  input  logic signed [8:0]             n,
  input  logic signed [8:0]             w,
  input  logic signed [8:0]             nw,
  input  logic signed [9:0]             fwd,
  input  logic [rct_pkg::SYM_W-1:0]     sym_in,
  output logic [rct_pkg::SYM_W-1:0]     sym_out,
  output logic signed [8:0]             rec
);

  logic signed [8:0]  lo;
  logic signed [8:0]  hi;
  logic signed [10:0] grad;
  logic signed [8:0]  pred;
  logic signed [10:0] err;
  logic signed [8:0]  unz;
  logic signed [9:0]  sum;
  logic signed [8:0]  rec_fwd;
  logic signed [8:0]  rec_inv;

  always_comb begin
    lo   = (n < w) ? n : w;
    hi   = (n < w) ? w : n;
    grad = 11'(n) + 11'(w) - 11'(nw);
    if (grad < 11'(lo)) begin
      pred = lo;
    end else if (grad > 11'(hi)) begin
      pred = hi;
    end else begin
      pred = grad[8:0];
    end
  end

  // Forward: wrap the residual and fold the sign into the low bit.
  always_comb begin
    err = 11'(fwd) - 11'(pred);
    if (is_luma) begin
      sym_out = {1'b0, {err[6:0], 1'b0} ^ {8{err[7]}}};
      rec_fwd = {fwd[7], fwd[7:0]};
    end else begin
      sym_out = {err[7:0], 1'b0} ^ {9{err[8]}};
      rec_fwd = fwd[8:0];
    end
  end

  // Inverse: unfold the symbol, add the prediction, wrap to channel width.
  always_comb begin
    unz = {1'b0, sym_in[8:1]} ^ {9{sym_in[0]}};
    sum = 10'(unz) + 10'(pred);
    if (is_luma) begin
      rec_inv = {sum[7], sum[7:0]};
    end else begin
      rec_inv = sum[8:0];
    end
  end

  assign rec = (mode == rct_pkg::MODE_INV) ? rec_inv : rec_fwd;

endmodule

### rtl/rct_merge.sv
// Merge stage: inverse color transform of the three lanes and selection of the output word.
module rct_merge (
  input  rct_pkg::lane_res_t               res,
  output logic [rct_pkg::DATA_W-1:0]       data
);

  logic signed [9:0] sum;
  logic signed [9:0] quarter;
  logic signed [9:0] g;
  logic signed [9:0] r;
  logic signed [9:0] b;
  logic [8:0]        out_a;
  logic [8:0]        out_b;
  logic [8:0]        out_c;

  always_comb begin
    sum     = 10'(res.rec_cb) + 10'(res.rec_cr);
    quarter = sum >>> 2;
    g       = 10'(res.rec_y) - quarter;
    r       = 10'(res.rec_cr) + g;
    b       = 10'(res.rec_cb) + g;
    if (res.mode == rct_pkg::MODE_INV) begin
      out_a = {1'b0, rct_pkg::bias128(r[7:0])};
      out_b = {1'b0, rct_pkg::bias128(g[7:0])};
      out_c = {1'b0, rct_pkg::bias128(b[7:0])};
    end else begin
      out_a = res.sym_a;
      out_b = res.sym_b;
      out_c = res.sym_c;
    end
    data = {5'b0, out_c, out_b, out_a};
  end

endmodule

### rtl/rct_med_residual_transform.sv
// Top level: pixel stream through the reversible color transform, median prediction and zigzag.
//
//  channel  | dir | handshake                     | carries
//  ---------+-----+-------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata in_a,in_b,in_c; tuser mode
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata out_a,out_b,out_c; tlast row_end
//  cfg      | in  | cfg_valid / cfg_ready         | row_width
//
//  One pixel per clock sustained while m_axis_tready stays high; m_axis_tvalid rises
//  behind the lane-result stage and the output register. Full rate holds because the read
//  of the next column's north pixel is issued in the same cycle as the current write.
//  After reset the line store is swept to zero with s_axis_tready low.
//  A row_width write holds s_axis_tready low for the following cycle while the store refetches.
//  A stall on m_axis backs up through the single lane-result stage to s_axis_tready.
module rct_med_residual_transform (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rct_pkg::ROW_WIDTH_W-1:0]   cfg_data,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rct_pkg::DATA_W-1:0]        s_axis_tdata,  // in_a[8:0], in_b[17:9], in_c[26:18]
  input  logic                              s_axis_tuser,  // mode
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rct_pkg::DATA_W-1:0]        m_axis_tdata,  // out_a[8:0], out_b[17:9], out_c[26:18]
  output logic                              m_axis_tlast   // row_end
);

  localparam logic [rct_pkg::CMP_W-1:0] MAX_W_C = rct_pkg::CMP_W'(rct_pkg::MAX_WIDTH);

  // Configuration and column tracking
  logic [rct_pkg::ROW_WIDTH_W-1:0] row_width;
  logic [rct_pkg::COL_W-1:0]       col;
  logic [rct_pkg::CMP_W-1:0]       rw_ext;
  logic [rct_pkg::CMP_W-1:0]       w_eff;
  logic [rct_pkg::COL_W-1:0]       col_eff;
  logic [rct_pkg::COL_W-1:0]       col_next;
  logic                            last;
  logic                            cfg_acc;
  logic                            refetch;

  // Neighbors
  rct_pkg::pix_t      north;
  rct_pkg::pix_t      west;
  rct_pkg::pix_t      northwest;
  rct_pkg::pix_t      w_sel;
  rct_pkg::pix_t      nw_sel;
  rct_pkg::store_wr_t st_wr;
  logic [rct_pkg::COL_W-1:0] rd_addr;
  logic               clearing;

  // Forward color transform
  logic signed [7:0] r8;
  logic signed [7:0] g8;
  logic signed [7:0] b8;
  logic signed [9:0] fwd_cb;
  logic signed [9:0] fwd_cr;
  logic signed [9:0] fwd_sum;
  logic signed [9:0] fwd_y;

  // Lanes and pipeline
  logic [rct_pkg::SYM_W-1:0] sym_a;
  logic [rct_pkg::SYM_W-1:0] sym_b;
  logic [rct_pkg::SYM_W-1:0] sym_c;
  logic signed [8:0]         rec_y;
  logic signed [8:0]         rec_cb;
  logic signed [8:0]         rec_cr;
  rct_pkg::lane_res_t        s1;
  logic                      s1_valid;
  logic [rct_pkg::DATA_W-1:0] merged;
  logic                      out_load;
  logic                      s1_adv;
  logic                      in_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= rct_pkg::ROW_WIDTH_W'(1);
    end else if (cfg_acc) begin
      row_width <= cfg_data;
    end
  end

  // Clamp the width into 1..MAX_WIDTH; a column past the width restarts the row.
  always_comb begin
    rw_ext = rct_pkg::CMP_W'(row_width);
    if (rw_ext == '0) begin
      w_eff = rct_pkg::CMP_W'(1);
    end else if (rw_ext > MAX_W_C) begin
      w_eff = MAX_W_C;
    end else begin
      w_eff = rw_ext;
    end
    col_eff  = (rct_pkg::CMP_W'(col) >= w_eff) ? '0 : col;
    last     = (rct_pkg::CMP_W'(col_eff) == (w_eff - 1'b1));
    col_next = last ? '0 : col_eff + 1'b1;
  end

  // Handshake: the lane-result stage moves on whenever the output register frees up.
  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign s1_adv        = s1_valid && out_load;
  assign s_axis_tready = (!s1_valid || out_load) && !clearing && !refetch;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Hold the input in the cycle after a width change or the clearing sweep
  // so the prefetched north pixel matches the column in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      refetch <= 1'b1;
    end else begin
      refetch <= cfg_acc || clearing;
    end
  end

  // Prefetch the next column on a transfer, else keep refreshing the current one.
  assign rd_addr    = in_acc ? col_next : col_eff;
  assign st_wr.en   = in_acc;
  assign st_wr.addr = col_eff;
  assign st_wr.data = '{cr: rec_cr, cb: rec_cb, y: rec_y[7:0]};

  rct_line_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (st_wr),
    .raddr    (rd_addr),
    .rdata    (north),
    .clearing (clearing)
  );

  // West and northwest read zero at the start of a row.
  assign w_sel  = (col_eff == '0) ? '0 : west;
  assign nw_sel = (col_eff == '0) ? '0 : northwest;

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      west      <= '0;
      northwest <= '0;
    end else if (in_acc) begin
      col       <= col_next;
      west      <= st_wr.data;
      northwest <= north;
    end
  end

  // Forward transform: remove the offset, then Cb = B-G, Cr = R-G, Y = G + floor((Cb+Cr)/4).
  always_comb begin
    r8      = rct_pkg::bias128(s_axis_tdata[7:0]);
    g8      = rct_pkg::bias128(s_axis_tdata[16:9]);
    b8      = rct_pkg::bias128(s_axis_tdata[25:18]);
    fwd_cb  = 10'(b8) - 10'(g8);
    fwd_cr  = 10'(r8) - 10'(g8);
    fwd_sum = fwd_cb + fwd_cr;
    fwd_y   = 10'(g8) + (fwd_sum >>> 2);
  end

  rct_lane u_lane_y (
    .mode    (s_axis_tuser),
    .is_luma (1'b1),
    .n       ({north.y[7], north.y}),
    .w       ({w_sel.y[7], w_sel.y}),
    .nw      ({nw_sel.y[7], nw_sel.y}),
    .fwd     (fwd_y),
    .sym_in  (s_axis_tdata[8:0]),
    .sym_out (sym_a),
    .rec     (rec_y)
  );

  rct_lane u_lane_cb (
    .mode    (s_axis_tuser),
    .is_luma (1'b0),
    .n       (north.cb),
    .w       (w_sel.cb),
    .nw      (nw_sel.cb),
    .fwd     (fwd_cb),
    .sym_in  (s_axis_tdata[17:9]),
    .sym_out (sym_b),
    .rec     (rec_cb)
  );

  rct_lane u_lane_cr (
    .mode    (s_axis_tuser),
    .is_luma (1'b0),
    .n       (north.cr),
    .w       (w_sel.cr),
    .nw      (nw_sel.cr),
    .fwd     (fwd_cr),
    .sym_in  (s_axis_tdata[26:18]),
    .sym_out (sym_c),
    .rec     (rec_cr)
  );

  // Lane-result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= '{mode: s_axis_tuser, last: last, sym_a: sym_a, sym_b: sym_b, sym_c: sym_c,
              rec_y: rec_y, rec_cb: rec_cb, rec_cr: rec_cr};
    end
  end

  rct_merge u_merge (
    .res  (s1),
    .data (merged)
  );

  // Output register: load on advance, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_axis_tdata <= merged;
      m_axis_tlast <= s1.last;
    end
  end

  // No pixel enters while the line store is being swept.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("input accepted during line store clear");

  // A width change must block the next cycle so the north pixel is refetched.
  a_refetch_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_acc |=> !s_axis_tready)
    else $error("input ready right after row_width write");

  // A forward luma symbol never exceeds eight bits.
  a_luma_sym_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1.mode == rct_pkg::MODE_FWD)) |-> (s1.sym_a[8] == 1'b0))
    else $error("forward Y symbol out of range");

endmodule

### bench/tb.sv
// Self-checking bench for the color transform, median prediction and zigzag block.
`timescale 1ns / 1ps

module tb;

  // Cycles with no transfer on any channel before the run is declared hung.
  // Covers the line store sweep after reset plus the longest stalls.
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic       mode;
    logic [8:0] a;
    logic [8:0] b;
    logic [8:0] c;
  } pixel_in_t;

  typedef struct packed {
    logic [8:0] a;
    logic [8:0] b;
    logic [8:0] c;
    logic       row_end;
  } pixel_out_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rct_pkg::ROW_WIDTH_W-1:0] cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rct_pkg::DATA_W-1:0]      s_axis_tdata = '0;   // in_a[8:0], in_b[17:9], in_c[26:18]
  logic                            s_axis_tuser = 1'b0; // mode
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [rct_pkg::DATA_W-1:0]      m_axis_tdata;        // out_a[8:0], out_b[17:9], out_c[26:18]
  logic                            m_axis_tlast;        // row_end

  rct_med_residual_transform dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pixels waiting to go out, and results owed by the block in arrival order.
  pixel_in_t  pixel_feed[$];
  pixel_out_t pixels_due[$];

  // Shadow of the block state: line store, west and north-west pixels, column.
  rct_pkg::pix_t                   line_above [0:rct_pkg::MAX_WIDTH-1];
  rct_pkg::pix_t                   west_pix;
  rct_pkg::pix_t                   nw_pix;
  int                              next_col;
  logic [rct_pkg::ROW_WIDTH_W-1:0] row_width_q;

  int errors = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_burst = 0;
  int recv_burst = 0;
  logic in_fired = 1'b0;
  logic out_fired = 1'b0;

  // Mostly short gaps, a few long ones, and now and then a stretch of none.
  function automatic int gap_len(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst = $urandom_range(40, 150);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int lane_of(rct_pkg::pix_t p, int k);
    case (k)
      0:       return $signed(p.y);
      1:       return $signed(p.cb);
      default: return $signed(p.cr);
    endcase
  endfunction

  function automatic int wrap_to(int x, int bits);
    if (bits == 8) return $signed(8'(x));
    return $signed(9'(x));
  endfunction

  function automatic logic [8:0] zigzag(int e, int bits);
    int z;
    z = (e >= 0) ? 2 * e : -2 * e - 1;
    if (bits == 8) return {1'b0, 8'(z)};
    return 9'(z);
  endfunction

  function automatic int unzigzag(logic [8:0] s);
    if (s[0]) return -int'(s[8:1]) - 1;
    return int'(s[8:1]);
  endfunction

  // Clamped gradient: N + W - NW held between min(N,W) and max(N,W).
  function automatic int med_predict(int n, int w, int nw);
    int lo, hi, p;
    lo = (n < w) ? n : w;
    hi = (n < w) ? w : n;
    p = n + w - nw;
    if (p < lo) p = lo;
    if (p > hi) p = hi;
    return p;
  endfunction

  // Work out the result of one accepted pixel and advance the shadow state.
  function automatic pixel_out_t transform_pixel(logic md, logic [8:0] a, logic [8:0] b,
                                                 logic [8:0] c);
    int eff_w, col, k, g, r, bl;
    int pr [3];
    int cur [3];
    rct_pkg::pix_t north, west, nw, done;
    pixel_out_t o;
    // Width 0 acts as 1, anything past the store depth as the full depth.
    eff_w = (row_width_q == 0) ? 1 :
            ((row_width_q > rct_pkg::MAX_WIDTH) ? rct_pkg::MAX_WIDTH : row_width_q);
    // Width lowered mid-row: the column wraps back to the row start.
    col = (next_col >= eff_w) ? 0 : next_col;
    north = line_above[col];
    west = (col == 0) ? '0 : west_pix;
    nw = (col == 0) ? '0 : nw_pix;
    for (k = 0; k < 3; k++)
      pr[k] = med_predict(lane_of(north, k), lane_of(west, k), lane_of(nw, k));
    if (md == rct_pkg::MODE_FWD) begin
      // Only the low byte of each color counts.
      r = int'(a[7:0]) - 128;
      g = int'(b[7:0]) - 128;
      bl = int'(c[7:0]) - 128;
      cur[1] = bl - g;
      cur[2] = r - g;
      cur[0] = g + ((cur[1] + cur[2]) >>> 2);
      o.a = zigzag(wrap_to(cur[0] - pr[0], 8), 8);
      o.b = zigzag(wrap_to(cur[1] - pr[1], 9), 9);
      o.c = zigzag(wrap_to(cur[2] - pr[2], 9), 9);
    end else begin
      // The full 9-bit Y symbol is unpacked, the sum then wraps to 8 bits.
      cur[0] = wrap_to(unzigzag(a) + pr[0], 8);
      cur[1] = wrap_to(unzigzag(b) + pr[1], 9);
      cur[2] = wrap_to(unzigzag(c) + pr[2], 9);
      g = cur[0] - ((cur[1] + cur[2]) >>> 2);
      r = cur[2] + g;
      bl = cur[1] + g;
      o.a = {1'b0, 8'(r + 128)};
      o.b = {1'b0, 8'(g + 128)};
      o.c = {1'b0, 8'(bl + 128)};
    end
    done.y = 8'(cur[0]);
    done.cb = 9'(cur[1]);
    done.cr = 9'(cur[2]);
    nw_pix = north;
    west_pix = done;
    line_above[col] = done;
    o.row_end = (col == eff_w - 1);
    next_col = o.row_end ? 0 : col + 1;
    return o;
  endfunction

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sample all handshakes at the rising edge: score results first, then
  // predict the pixel accepted at this same edge.
  always @(posedge clk) begin : score
    pixel_out_t want;
    in_fired = 1'b0;
    out_fired = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_fired = 1'b1;
        if (pixels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pixels_due.pop_front();
          check_field("out_a", want.a, m_axis_tdata[8:0]);
          check_field("out_b", want.b, m_axis_tdata[17:9]);
          check_field("out_c", want.c, m_axis_tdata[26:18]);
          check_field("row_end", {8'd0, want.row_end}, {8'd0, m_axis_tlast});
        end
      end
      if (cfg_valid && cfg_ready)
        row_width_q = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        in_fired = 1'b1;
        pixels_due.push_back(transform_pixel(s_axis_tuser, s_axis_tdata[8:0],
                                             s_axis_tdata[17:9], s_axis_tdata[26:18]));
      end
      if (in_fired || out_fired || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("rct_med_residual_transform verification failed");
          $finish;
        end
      end
    end
  end

  // Pixel sender: advance on a transfer or from idle, hold otherwise.
  always @(negedge clk) begin : drive_pixels
    pixel_in_t nx;
    if (!rst && (!s_axis_tvalid || in_fired)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_feed.size() > 0) begin
        nx = pixel_feed.pop_front();
        s_axis_tdata <= {5'd0, nx.c, nx.b, nx.a};
        s_axis_tuser <= nx.mode;
        s_axis_tvalid <= 1'b1;
        send_gap = gap_len(send_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: after each transfer draw a fresh stall.
  always @(negedge clk) begin : take_results
    if (out_fired)
      recv_gap = gap_len(recv_burst);
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_pixel(logic md, logic [8:0] a, logic [8:0] b, logic [8:0] c);
    pixel_in_t p;
    p.mode = md;
    p.a = a;
    p.b = b;
    p.c = c;
    pixel_feed.push_back(p);
  endtask

  // Hold until every queued pixel went out and every result came back,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (pixel_feed.size() != 0 || s_axis_tvalid || pixels_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_row_width(logic [rct_pkg::ROW_WIDTH_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Queue n pixels in runs of one flavor: smooth images, small residual
  // symbols (the usual case), full-range noise and mixed-mode noise.
  task automatic add_random_pixels(int n);
    int left, run, flavor, k, rr, gg, bb;
    left = n;
    while (left > 0) begin
      run = $urandom_range(4, 40);
      if (run > left) run = left;
      flavor = $urandom_range(0, 99);
      rr = $urandom_range(0, 255);
      gg = $urandom_range(0, 255);
      bb = $urandom_range(0, 255);
      for (k = 0; k < run; k++) begin
        if (flavor < 35) begin
          rr = (rr + $urandom_range(0, 6) - 3) & 255;
          gg = (gg + $urandom_range(0, 6) - 3) & 255;
          bb = (bb + $urandom_range(0, 6) - 3) & 255;
          push_pixel(rct_pkg::MODE_FWD, 9'(rr), 9'(gg), 9'(bb));
        end else if (flavor < 60) begin
          push_pixel(rct_pkg::MODE_INV, 9'($urandom_range(0, 7)), 9'($urandom_range(0, 7)),
                     9'($urandom_range(0, 7)));
        end else if (flavor < 75) begin
          push_pixel(rct_pkg::MODE_FWD, 9'($urandom), 9'($urandom), 9'($urandom));
        end else if (flavor < 90) begin
          push_pixel(rct_pkg::MODE_INV, 9'($urandom), 9'($urandom), 9'($urandom));
        end else begin
          push_pixel(($urandom_range(0, 1) == 1) ? rct_pkg::MODE_INV : rct_pkg::MODE_FWD,
                     9'($urandom), 9'($urandom), 9'($urandom));
        end
      end
      left -= run;
    end
  endtask

  initial begin : stimulus
    int p, n, w;
    foreach (line_above[i]) line_above[i] = '0;
    west_pix = '0;
    nw_pix = '0;
    next_col = 0;
    row_width_q = 1;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset width of one: every pixel ends its row, N comes from the store.
    push_pixel(rct_pkg::MODE_FWD, 9'd0, 9'd0, 9'd0);
    push_pixel(rct_pkg::MODE_FWD, 9'd255, 9'd255, 9'd255);
    push_pixel(rct_pkg::MODE_INV, 9'd0, 9'd0, 9'd0);
    wait_drained();

    // Width zero behaves as one.
    write_row_width(13'd0);
    push_pixel(rct_pkg::MODE_FWD, 9'd128, 9'd128, 9'd128);
    push_pixel(rct_pkg::MODE_INV, 9'd511, 9'd511, 9'd511);
    wait_drained();

    // Two rows of four: color extremes, bytes with the ninth bit set,
    // inverse Y symbols past 255 and symbol extremes.
    write_row_width(13'd4);
    push_pixel(rct_pkg::MODE_FWD, 9'd255, 9'd0, 9'd255);
    push_pixel(rct_pkg::MODE_FWD, 9'd0, 9'd255, 9'd0);
    push_pixel(rct_pkg::MODE_FWD, 9'd511, 9'd256, 9'd384);
    push_pixel(rct_pkg::MODE_FWD, 9'd256, 9'd511, 9'd257);
    push_pixel(rct_pkg::MODE_INV, 9'd255, 9'd0, 9'd1);
    push_pixel(rct_pkg::MODE_INV, 9'd256, 9'd511, 9'd510);
    push_pixel(rct_pkg::MODE_INV, 9'd1, 9'd2, 9'd3);
    push_pixel(rct_pkg::MODE_INV, 9'd510, 9'd1, 9'd0);
    wait_drained();

    // Lower the width mid-row: column three is past a width of two, so the
    // next pixel starts a new row.
    write_row_width(13'd5);
    push_pixel(rct_pkg::MODE_FWD, 9'd10, 9'd20, 9'd30);
    push_pixel(rct_pkg::MODE_FWD, 9'd12, 9'd22, 9'd28);
    push_pixel(rct_pkg::MODE_INV, 9'd4, 9'd3, 9'd2);
    wait_drained();
    write_row_width(13'd2);
    push_pixel(rct_pkg::MODE_FWD, 9'd200, 9'd100, 9'd50);
    push_pixel(rct_pkg::MODE_INV, 9'd7, 9'd8, 9'd9);
    push_pixel(rct_pkg::MODE_FWD, 9'd60, 9'd70, 9'd80);
    wait_drained();

    // Width beyond the store depth clamps to the full depth.
    write_row_width(13'd8191);
    push_pixel(rct_pkg::MODE_FWD, 9'd1, 9'd2, 9'd3);
    push_pixel(rct_pkg::MODE_INV, 9'd300, 9'd5, 9'd6);
    wait_drained();

    // Random phases over a spread of widths; most changes land mid-row.
    for (p = 0; p < 12; p++) begin
      case (p)
        0:       w = 1;
        1:       w = 2;
        2:       w = 3;
        3:       w = 8;
        4:       w = 17;
        5:       w = 64;
        6:       w = 4096;
        7:       w = 8191;
        10:      w = 5;
        11:      w = 31;
        default: w = $urandom_range(1, 300);
      endcase
      write_row_width(13'(w));
      n = $urandom_range(110, 160);
      if (p == 5) begin
        // Starve the block mid-phase until all results are back.
        add_random_pixels(n / 2);
        wait_drained();
        add_random_pixels(n - n / 2);
      end else begin
        add_random_pixels(n);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("rct_med_residual_transform verification clean");
    end else begin
      $display("rct_med_residual_transform verification failed");
    end
    $finish;
  end

endmodule

### rct_med_residual_transform.f
rtl/rct_pkg.sv
rtl/rct_line_store.sv
rtl/rct_lane.sv
rtl/rct_merge.sv
rtl/rct_med_residual_transform.sv
bench/tb.sv
